### sv/prtt_pkg.sv
// Shared types and constants for the pending request timeout table.
// Operation codes, ticket types, result kinds and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package prtt_pkg;

	// Fixed field widths of the stream payload.
	localparam int KEY_W  = 64;
	localparam int PAY_W  = 32;
	localparam int TIME_W = 32;
	localparam int TO_W   = 16;

	// Timeout after reset, in seconds.
	localparam logic [TO_W-1:0] TIMEOUT_RESET = 16'd5;

	// Operation selector carried on the input side.
	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_CHECK = 2'd1,
		OP_REAP  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	// Ticket types with a special meaning; any other code is stored and matched as is.
	localparam logic [1:0] TT_TOKEN   = 2'd0;
	localparam logic [1:0] TT_SERVICE = 2'd1;

	// Result kinds.
	localparam logic [1:0] KIND_SUMMARY = 2'd0;
	localparam logic [1:0] KIND_MATCH   = 2'd1;
	localparam logic [1:0] KIND_EXPIRY  = 2'd2;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SUM
	} state_t;

endpackage

`default_nettype wire

### sv/pending_request_timeout_table_unit.sv
// Top level of the pending request timeout table: entry memory, scan sequencer
// and the output register. Depends on prtt_pkg.
//
// Channel   Direction  Handshake            Contents
// s_*       in         s_tvalid / s_tready  one operation: add, check, reap or clear
// m_*       out        m_tvalid / m_tready  match or expiry events, then one summary
// cfg_*     in         cfg_we               timeout in seconds
//
// Add and clear go straight to the summary. Check and reap scan all fill entries,
// where fill is the entry count: the scan reads one memory entry per cycle while no
// event stalls, and copies the survivors down in the same pass through the read and write port.
// Reset clears the entry count and the output valid; the memory needs no clearing.
// A stalled output holds the scan on an entry that raises an event until the event is taken.
`timescale 1ns / 1ps
`default_nettype none

module pending_request_timeout_table_unit #(
	parameter int DEPTH    = 16,
	parameter int KEY_BITS = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Input stream.
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,   // key[63:0], payload[95:64], time_now[127:96]
	input  wire logic [7:0]   s_tuser,   // op[1:0], ticket_type[3:2], zeros above
	// Output stream.
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [95:0]       m_tdata,   // entry_key[63:0], entry_payload[95:64]
	output logic [7:0]        m_tuser,   // kind[1:0], entry_kind[3:2], found[4], full_res[5]
	output logic              m_tlast,
	// Configuration.
	input  wire logic         cfg_we,
	input  wire logic [15:0]  cfg_wdata
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = 2 + KEY_BITS + prtt_pkg::PAY_W + prtt_pkg::TIME_W;
	localparam int K_LO = 2;
	localparam int P_LO = K_LO + KEY_BITS;
	localparam int T_LO = P_LO + prtt_pkg::PAY_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	prtt_pkg::state_t state_q, state_d;

	// Entry memory: type, key, payload and time packed from the lowest bit up.
	logic [EW-1:0] mem_q [DEPTH];
	logic [EW-1:0] rdata_q;
	logic [IW-1:0] raddr, waddr;
	logic [EW-1:0] wdata;
	logic          mem_we;

	// Control and the latched operation.
	logic [CW-1:0]               fill_q, rd_q, wr_q;
	logic [prtt_pkg::TO_W-1:0]   timeout_q;
	prtt_pkg::op_t               op_q;
	logic [1:0]                  typ_q;
	logic [KEY_BITS-1:0]         key_q;
	logic [prtt_pkg::TIME_W-1:0] now_q;
	logic                        found_q, full_q, stop_q;

	// Output register.
	logic                        ovalid_q, olast_q, ofound_q, ofull_q;
	logic [1:0]                  okind_q, oekind_q;
	logic [prtt_pkg::KEY_W-1:0]  okey_q;
	logic [prtt_pkg::PAY_W-1:0]  opay_q;

	// Decoded view of the entry under examination.
	logic [1:0]                  e_type;
	logic [KEY_BITS-1:0]         e_key;
	logic [prtt_pkg::PAY_W-1:0]  e_pay;
	logic [prtt_pkg::TIME_W-1:0] e_time;
	logic [prtt_pkg::TIME_W-1:0] age;

	logic accept, scan_end, remove, emit, out_free, adv, ev_load, sum_load;
	prtt_pkg::op_t in_op;

	assign e_type = rdata_q[1:0];
	assign e_key  = rdata_q[K_LO +: KEY_BITS];
	assign e_pay  = rdata_q[P_LO +: prtt_pkg::PAY_W];
	assign e_time = rdata_q[T_LO +: prtt_pkg::TIME_W];
	assign age    = now_q - e_time;

	assign in_op    = prtt_pkg::op_t'(s_tuser[1:0]);
	assign s_tready = (state_q == prtt_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !ovalid_q || m_tready;
	assign scan_end = (rd_q == fill_q);

	// Removal and event decision for the current entry.
	always_comb begin
		logic match_chk, expired;
		match_chk = (op_q == prtt_pkg::OP_CHECK) && (e_type == typ_q) &&
			(e_key == key_q) && !stop_q;
		expired = (op_q == prtt_pkg::OP_REAP) &&
			(age >= prtt_pkg::TIME_W'(timeout_q));
		remove = !scan_end && (match_chk || expired);
		emit = remove && ((op_q == prtt_pkg::OP_CHECK) || (e_type == prtt_pkg::TT_SERVICE));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			prtt_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_op == prtt_pkg::OP_CHECK || in_op == prtt_pkg::OP_REAP)
						state_d = prtt_pkg::ST_SCAN;
					else
						state_d = prtt_pkg::ST_SUM;
				end
			end
			prtt_pkg::ST_SCAN: begin
				if (scan_end)
					state_d = prtt_pkg::ST_SUM;
			end
			prtt_pkg::ST_SUM: begin
				if (out_free)
					state_d = prtt_pkg::ST_IDLE;
			end
			default: state_d = prtt_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: memory port control and output register loads.
	always_comb begin
		adv      = 1'b0;
		ev_load  = 1'b0;
		sum_load = 1'b0;
		mem_we   = 1'b0;
		raddr    = '0;
		waddr    = wr_q[IW-1:0];
		wdata    = rdata_q;
		case (state_q)
			prtt_pkg::ST_IDLE: begin
				// An add appends at the fill position when there is room.
				if (accept && in_op == prtt_pkg::OP_ADD && fill_q != DEPTH_C) begin
					mem_we = 1'b1;
					waddr  = fill_q[IW-1:0];
					wdata  = {s_tdata[127:96], s_tdata[95:64], s_tdata[KEY_BITS-1:0],
						s_tuser[3:2]};
				end
			end
			prtt_pkg::ST_SCAN: begin
				adv     = !scan_end && (!emit || out_free);
				ev_load = adv && emit;
				mem_we  = adv && !remove;
				raddr   = adv ? IW'(rd_q + CW'(1)) : rd_q[IW-1:0];
			end
			prtt_pkg::ST_SUM: begin
				sum_load = out_free;
			end
			default: begin
				adv = 1'b0;
			end
		endcase
	end

	// Entry memory with a registered read.
	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= prtt_pkg::ST_IDLE;
			fill_q    <= '0;
			rd_q      <= '0;
			wr_q      <= '0;
			timeout_q <= prtt_pkg::TIMEOUT_RESET;
			found_q   <= 1'b0;
			full_q    <= 1'b0;
			stop_q    <= 1'b0;
			ovalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				timeout_q <= cfg_wdata;
			if (accept) begin
				rd_q    <= '0;
				wr_q    <= '0;
				found_q <= 1'b0;
				stop_q  <= 1'b0;
				full_q  <= (in_op == prtt_pkg::OP_ADD) && (fill_q == DEPTH_C);
				if (in_op == prtt_pkg::OP_ADD && fill_q != DEPTH_C)
					fill_q <= fill_q + CW'(1);
				else if (in_op == prtt_pkg::OP_CLEAR)
					fill_q <= '0;
			end
			// Scan step: a kept entry moves down to the write position.
			if (adv) begin
				rd_q <= rd_q + CW'(1);
				if (remove) begin
					found_q <= 1'b1;
					if (typ_q == prtt_pkg::TT_TOKEN)
						stop_q <= 1'b1;
				end else begin
					wr_q <= wr_q + CW'(1);
				end
			end
			if (state_q == prtt_pkg::ST_SCAN && scan_end)
				fill_q <= wr_q;
			// Output valid follows loads and transfers.
			if (ev_load || sum_load)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
		end
	end

	// Latched operation and output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_op;
			typ_q <= s_tuser[3:2];
			key_q <= s_tdata[KEY_BITS-1:0];
			now_q <= s_tdata[127:96];
		end
		if (ev_load) begin
			okind_q  <= (op_q == prtt_pkg::OP_CHECK) ? prtt_pkg::KIND_MATCH
				: prtt_pkg::KIND_EXPIRY;
			oekind_q <= e_type;
			okey_q   <= prtt_pkg::KEY_W'(e_key);
			opay_q   <= e_pay;
			ofound_q <= 1'b0;
			ofull_q  <= 1'b0;
			olast_q  <= 1'b0;
		end else if (sum_load) begin
			okind_q  <= prtt_pkg::KIND_SUMMARY;
			oekind_q <= '0;
			okey_q   <= '0;
			opay_q   <= '0;
			ofound_q <= found_q && (op_q == prtt_pkg::OP_CHECK);
			ofull_q  <= full_q && (op_q == prtt_pkg::OP_ADD);
			olast_q  <= 1'b1;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {opay_q, okey_q};
	assign m_tuser  = {2'b00, ofull_q, ofound_q, oekind_q, okind_q};
	assign m_tlast  = olast_q;

`ifndef SYNTHESIS
	// The entry count never exceeds the table size.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("entry count beyond table size");

	// During a scan the write position trails the read position, which stays in the table.
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == prtt_pkg::ST_SCAN) |-> (wr_q <= rd_q && rd_q <= fill_q))
		else $error("scan positions out of order");

	// The final result of an operation is always a summary.
	a_last_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser[1:0] == prtt_pkg::KIND_SUMMARY))
		else $error("last result is not a summary");

	// A waiting event is not overwritten by the scan.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !m_tready) |-> !(ev_load || sum_load))
		else $error("output register overwritten while stalled");
`endif

endmodule

`default_nettype wire
